/* hw/rtl/ocod_pkg.sv */
// shared constants for the one-compartment oral dose step core
package ocod_pkg;

  localparam int RATE_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 2;
  localparam int AMOUNT_FRAC_BITS_DEF = 16;

  localparam logic [RATE_W-1:0] KEL_RESET = 24'd104858;
  localparam logic [RATE_W-1:0] KA_RESET  = 24'd104858;
  localparam logic [FRAC_W-1:0] F_RESET   = 16'd32768;

  localparam logic [IDX_W-1:0] REG_KEL = 2'd0;
  localparam logic [IDX_W-1:0] REG_KA  = 2'd1;
  localparam logic [IDX_W-1:0] REG_F   = 2'd2;

  localparam logic [31:0] EXP_ONE        = 32'h8000_0000;
  localparam logic [63:0] COLLAPSE_LIMIT = 64'd68720;
  localparam logic [3:0]  TAYLOR_TERMS   = 4'd8;
  localparam logic [3:0]  SQUARINGS_LAST = 4'd7;
  localparam logic [5:0]  DIV_BATEMAN_N  = 6'd56;

endpackage

/* hw/rtl/one_compartment_oral_dose_step_core.sv */
// one-compartment oral dose step core: sequencer around one shared multiplier and divider
//
// Input channel in_*: one timeline point (sample_time, dose_amount) per item,
// taken when in_valid is high and in_stall is low. in_stall stays high from
// acceptance until the result item has been taken.
// Output channel out_*: one result item (time, depot and central amounts)
// per input item, held in output registers until out_stall is low.
// Configuration port cfg_*: always ready; index 0 elimination rate, 1 absorption
// rate, 2 bioavailability; other indexes are ignored. Write only while idle.
// Steps per item: the first point after reset does the dose add only. Later
// points compute two exponentials (eight Taylor terms, each a multiply and a
// reciprocal multiply for the divide by the term index, then eight squarings
// on the shared 32x32 multiplier; skipped when past cutoff), then a serial
// divide for the Bateman factor, or a multiply when diffk * dt is below the
// collapse limit. A new item is taken only once the result has been taken.
// Reset (rst_n low, synchronous) restores the default rates, clears the
// amounts, the last time and the first-point flag.
// A stalled result holds its payload and keeps the block from taking input.
module one_compartment_oral_dose_step_core #(
  parameter int AMOUNT_FRAC_BITS = ocod_pkg::AMOUNT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ocod_pkg::VAL_W-1:0]    in_sample_time,
  input  logic [ocod_pkg::VAL_W-1:0]    in_dose_amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ocod_pkg::VAL_W-1:0]    out_time,
  output logic [ocod_pkg::VAL_W-1:0]    out_depot_amount,
  output logic [ocod_pkg::VAL_W-1:0]    out_central_amount,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ocod_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ocod_pkg::RATE_W-1:0]   cfg_data
);
  import ocod_pkg::*;

  localparam int DOSE_SHIFT = 31 - AMOUNT_FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_MKEL, S_XEL, S_XA, S_XD, S_EXP_INIT, S_T_MUL, S_T_DIV, S_DIV,
    S_T_ACC, S_SQ_MUL, S_SQ_TAKE, S_EXP_DONE, S_MDEP, S_MCEN, S_MFAC, S_CFAC,
    S_BDIV, S_BFAC, S_GAIN, S_GSUM, S_DOSE, S_DADD, S_OUT
  } state_t;

  state_t state_r;

  logic [RATE_W-1:0] kel_r, ka_r;
  logic [FRAC_W-1:0] f_r;
  logic [31:0] prev_time_r, depot_r, central_r;
  logic        have_first_r;
  logic [31:0] t_r, dose_r, dt_r;
  logic [55:0] xel_r, xa_r;
  logic        coll_r, which_r;
  logic [27:0] y_r;
  logic [31:0] term_r, acc_r, e_el_r, e_a_r, ag_end_r, acdec_r, factor_r;
  logic [3:0]  k_r, sq_r;
  logic [55:0] dq_r;
  logic [24:0] dr_r;
  logic [RATE_W-1:0] dv_r;
  logic [5:0]  dn_r;
  logic [63:0] prod_r;
  logic        out_valid_r;
  logic [31:0] out_time_r, out_depot_r, out_central_r;

  logic [31:0] mul_a, mul_b;
  logic [RATE_W-1:0] diffk;
  logic [31:0] d_val;
  logic [55:0] x_cur;
  logic        cutoff;
  logic [25:0] r2;
  logic        ge;
  logic [24:0] dr_nxt;
  logic [31:0] taylor_q;
  logic [31:0] recip;
  logic [63:0] dose_add;
  logic [64:0] depot_sum;
  logic [32:0] central_sum;
  logic [63:0] cfac_raw;

  assign diffk    = (ka_r > kel_r) ? ka_r - kel_r : kel_r - ka_r;
  assign d_val    = (ka_r > kel_r) ? ((e_el_r > e_a_r) ? e_el_r - e_a_r : 32'd0)
                                   : ((e_a_r > e_el_r) ? e_a_r - e_el_r : 32'd0);
  assign x_cur    = which_r ? xa_r : xel_r;
  assign cutoff   = |x_cur[55:41];
  assign r2       = {dr_r, dq_r[55]};
  assign ge       = r2 >= {2'b00, dv_r};
  assign dr_nxt   = ge ? 25'(r2 - {2'b00, dv_r}) : r2[24:0];
  assign taylor_q = prod_r[62:31];
  assign dose_add = prod_r >> DOSE_SHIFT;
  assign depot_sum   = {33'd0, depot_r} + {1'b0, dose_add};
  assign central_sum = {1'b0, acdec_r} + {1'b0, prod_r[62:31]};
  assign cfac_raw    = prod_r >> 23;

  // ceil(2^31 / k), exact for dividends below 2^28
  always_comb begin
    case (k_r)
      4'd1:    recip = 32'h8000_0000;
      4'd2:    recip = 32'h4000_0000;
      4'd3:    recip = 32'h2AAA_AAAB;
      4'd4:    recip = 32'h2000_0000;
      4'd5:    recip = 32'h1999_999A;
      4'd6:    recip = 32'h1555_5556;
      4'd7:    recip = 32'h1249_2493;
      4'd8:    recip = 32'h1000_0000;
      default: recip = 32'd0;
    endcase
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_MKEL:   begin mul_a = {8'd0, kel_r};  mul_b = dt_r; end
      S_XEL:    begin mul_a = {8'd0, ka_r};   mul_b = dt_r; end
      S_XA:     begin mul_a = {8'd0, diffk};  mul_b = dt_r; end
      S_T_MUL:  begin mul_a = term_r;         mul_b = {4'd0, y_r}; end
      S_T_DIV:  begin mul_a = prod_r[62:31];  mul_b = recip; end
      S_SQ_MUL: begin mul_a = acc_r;          mul_b = acc_r; end
      S_MDEP:   begin mul_a = depot_r;        mul_b = e_a_r; end
      S_MCEN:   begin mul_a = central_r;      mul_b = e_el_r; end
      S_MFAC: begin
        if (coll_r) begin
          mul_a = {4'd0, xel_r[40:13]};
          mul_b = e_el_r;
        end else begin
          mul_a = {8'd0, ka_r};
          mul_b = d_val;
        end
      end
      S_GAIN:   begin mul_a = depot_r;        mul_b = factor_r; end
      S_DOSE:   begin mul_a = dose_r;         mul_b = {16'd0, f_r}; end
      default:  begin mul_a = 32'd0;          mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kel_r        <= KEL_RESET;
      ka_r         <= KA_RESET;
      f_r          <= F_RESET;
      prev_time_r  <= 32'd0;
      depot_r      <= 32'd0;
      central_r    <= 32'd0;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEL: kel_r <= cfg_data;
          REG_KA:  ka_r  <= cfg_data;
          REG_F:   f_r   <= cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r    <= in_sample_time;
            dose_r <= in_dose_amount;
            dt_r   <= (in_sample_time >= prev_time_r) ? in_sample_time - prev_time_r
                                                      : 32'd0;
            state_r <= have_first_r ? S_MKEL : S_DOSE;
          end
        end
        S_MKEL: state_r <= S_XEL;
        S_XEL: begin
          xel_r   <= prod_r[55:0];
          state_r <= S_XA;
        end
        S_XA: begin
          xa_r    <= prod_r[55:0];
          state_r <= S_XD;
        end
        S_XD: begin
          coll_r  <= prod_r < COLLAPSE_LIMIT;
          which_r <= 1'b0;
          state_r <= S_EXP_INIT;
        end
        S_EXP_INIT: begin
          if (cutoff) begin
            acc_r   <= 32'd0;
            state_r <= S_EXP_DONE;
          end else begin
            y_r     <= x_cur[40:13];
            term_r  <= EXP_ONE;
            acc_r   <= EXP_ONE;
            k_r     <= 4'd1;
            state_r <= S_T_MUL;
          end
        end
        S_T_MUL: state_r <= S_T_DIV;
        S_T_DIV: state_r <= S_T_ACC;
        S_DIV: begin
          dr_r <= dr_nxt;
          dq_r <= {dq_r[54:0], ge};
          dn_r <= dn_r - 6'd1;
          if (dn_r == 6'd1) begin
            state_r <= S_BFAC;
          end
        end
        S_T_ACC: begin
          term_r <= taylor_q;
          acc_r  <= k_r[0] ? acc_r - taylor_q : acc_r + taylor_q;
          if (k_r == TAYLOR_TERMS) begin
            sq_r    <= 4'd0;
            state_r <= S_SQ_MUL;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_T_MUL;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_TAKE;
        S_SQ_TAKE: begin
          acc_r <= prod_r[62:31];
          sq_r  <= sq_r + 4'd1;
          state_r <= (sq_r == SQUARINGS_LAST) ? S_EXP_DONE : S_SQ_MUL;
        end
        S_EXP_DONE: begin
          if (!which_r) begin
            e_el_r  <= acc_r;
            which_r <= 1'b1;
            state_r <= S_EXP_INIT;
          end else begin
            e_a_r   <= acc_r;
            state_r <= S_MDEP;
          end
        end
        S_MDEP: state_r <= S_MCEN;
        S_MCEN: begin
          ag_end_r <= prod_r[62:31];
          state_r  <= S_MFAC;
        end
        S_MFAC: begin
          acdec_r <= prod_r[62:31];
          if (coll_r) begin
            if (|xel_r[55:41]) begin
              factor_r <= 32'd0;
              state_r  <= S_GAIN;
            end else begin
              state_r  <= S_CFAC;
            end
          end else begin
            state_r <= S_BDIV;
          end
        end
        S_CFAC: begin
          factor_r <= (cfac_raw > {32'd0, EXP_ONE}) ? EXP_ONE : cfac_raw[31:0];
          state_r  <= S_GAIN;
        end
        S_BDIV: begin
          dq_r      <= prod_r[55:0];
          dr_r      <= 25'd0;
          dv_r      <= diffk;
          dn_r      <= DIV_BATEMAN_N;
          state_r   <= S_DIV;
        end
        S_BFAC: begin
          factor_r <= (dq_r > {24'd0, EXP_ONE}) ? EXP_ONE : dq_r[31:0];
          state_r  <= S_GAIN;
        end
        S_GAIN: state_r <= S_GSUM;
        S_GSUM: begin
          central_r <= central_sum[32] ? 32'hFFFF_FFFF : central_sum[31:0];
          depot_r   <= ag_end_r;
          state_r   <= S_DOSE;
        end
        S_DOSE: state_r <= S_DADD;
        S_DADD: begin
          depot_r       <= (|depot_sum[64:32]) ? 32'hFFFF_FFFF : depot_sum[31:0];
          out_depot_r   <= (|depot_sum[64:32]) ? 32'hFFFF_FFFF : depot_sum[31:0];
          out_central_r <= central_r;
          out_time_r    <= t_r;
          prev_time_r   <= t_r;
          have_first_r  <= 1'b1;
          out_valid_r   <= 1'b1;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_time           = out_time_r;
  assign out_depot_amount   = out_depot_r;
  assign out_central_amount = out_central_r;

endmodule

/* hw/rtl/ocod_checker.sv */
// port-level checker for the one-compartment oral dose step core, with bind
module ocod_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_time
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time))
    else $error("result changed while stalled");

  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("result or ready right after accepting item");

  a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid && !in_stall)
    else $error("not ready after result taken");

endmodule

bind one_compartment_oral_dose_step_core ocod_checker u_ocod_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_time  (out_time)
);

/* dv/one_compartment_oral_dose_step_core_tb.sv */
// self-checking testbench for the one-compartment oral dose step core
`timescale 1ns / 1ps

module one_compartment_oral_dose_step_core_tb;
  import ocod_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] dose;
  } point_t;

  typedef struct {
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] depot;
    logic [VAL_W-1:0] central;
  } amounts_t;

  localparam int FRAC_BITS = AMOUNT_FRAC_BITS_DEF;
  localparam logic [63:0] EXP_UNIT = 64'd1 << 31;
  localparam logic [63:0] EXP_ZERO_AT = 64'd32 << 36;
  localparam logic [63:0] AMT_MAX = 64'hFFFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [VAL_W-1:0] in_sample_time;
  logic [VAL_W-1:0] in_dose_amount;
  logic out_valid;
  logic out_stall;
  logic [VAL_W-1:0] out_time;
  logic [VAL_W-1:0] out_depot_amount;
  logic [VAL_W-1:0] out_central_amount;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0] cfg_data;

  point_t pending_points[$];
  amounts_t expected_amounts[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int quiet_cycles;
  bit point_taken;
  logic [VAL_W-1:0] next_time;

  logic [RATE_W-1:0] kel_q;
  logic [RATE_W-1:0] ka_q;
  logic [FRAC_W-1:0] bio_q;
  logic [VAL_W-1:0] last_time;
  logic [VAL_W-1:0] depot_amt;
  logic [VAL_W-1:0] central_amt;
  bit seen_point;

  one_compartment_oral_dose_step_core u_top (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] exp_decay_q31(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    if (x >= EXP_ZERO_AT) return 64'd0;
    y = x >> 13;
    term = EXP_UNIT;
    acc = EXP_UNIT;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * y) >> 31) / k;
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    for (int k = 0; k < 8; k++) acc = (acc * acc) >> 31;
    return acc;
  endfunction

  function automatic logic [VAL_W-1:0] sat_amt(logic [63:0] v);
    return (v > AMT_MAX) ? AMT_MAX[VAL_W-1:0] : v[VAL_W-1:0];
  endfunction

  function automatic void advance_compartments(logic [VAL_W-1:0] dt);
    logic [63:0] kel;
    logic [63:0] ka;
    logic [63:0] e_el;
    logic [63:0] e_a;
    logic [63:0] ag;
    logic [63:0] ac_dec;
    logic [63:0] diffk;
    logic [63:0] factor;
    logic [63:0] x;
    logic [63:0] d;
    kel = kel_q;
    ka = ka_q;
    e_el = exp_decay_q31(kel * dt);
    e_a = exp_decay_q31(ka * dt);
    ag = depot_amt;
    ac_dec = (64'(central_amt) * e_el) >> 31;
    diffk = (ka > kel) ? ka - kel : kel - ka;
    if (diffk * dt < COLLAPSE_LIMIT) begin
      x = kel * dt;
      factor = (x >= EXP_ZERO_AT) ? 64'd0 : (((x >> 13) * e_el) >> 23);
    end else begin
      if (ka > kel) d = (e_el > e_a) ? e_el - e_a : 64'd0;
      else d = (e_a > e_el) ? e_a - e_el : 64'd0;
      factor = (ka * d) / diffk;
    end
    if (factor > EXP_UNIT) factor = EXP_UNIT;
    depot_amt = 32'((ag * e_a) >> 31);
    central_amt = sat_amt(ac_dec + ((ag * factor) >> 31));
  endfunction

  function automatic amounts_t dose_step(point_t p);
    amounts_t r;
    logic [63:0] add;
    if (seen_point) advance_compartments((p.t >= last_time) ? p.t - last_time : '0);
    seen_point = 1'b1;
    last_time = p.t;
    add = (64'(p.dose) * 64'(bio_q)) >> (31 - FRAC_BITS);
    depot_amt = sat_amt(64'(depot_amt) + add);
    r.t = p.t;
    r.depot = depot_amt;
    r.central = central_amt;
    return r;
  endfunction

  task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || point_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid <= 1'b1;
        in_sample_time <= p.t;
        in_dose_amount <= p.dose;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    point_t p;
    amounts_t want;
    point_taken = rst_n && in_valid && !in_stall;
    if (point_taken) begin
      p.t = in_sample_time;
      p.dose = in_dose_amount;
      expected_amounts = {expected_amounts, dose_step(p)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_amounts.size() == 0) begin
        report("unexpected item time", out_time, '0);
      end else begin
        want = expected_amounts.pop_front();
        if (out_time !== want.t) report("time", out_time, want.t);
        if (out_depot_amount !== want.depot) report("depot", out_depot_amount, want.depot);
        if (out_central_amount !== want.central)
          report("central", out_central_amount, want.central);
      end
    end
    if (point_taken || (out_valid && !out_stall) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("one_compartment_oral_dose_step_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEL: kel_q = val;
      REG_KA: ka_q = val;
      REG_F: bio_q = val[FRAC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_amounts.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_point(logic [VAL_W-1:0] t, logic [VAL_W-1:0] dose);
    point_t p;
    p.t = t;
    p.dose = dose;
    pending_points = {pending_points, p};
    next_time = t;
  endtask

  task automatic add_random(int n);
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] dose;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 65) t = next_time + $urandom_range(32'h8_0000);
      else if (sel < 75) t = next_time - $urandom_range(32'h4_0000);
      else if (sel < 85) t = next_time + $urandom_range(40);
      else if (sel < 92) t = next_time;
      else t = $urandom;
      sel = $urandom_range(99);
      if (sel < 45) dose = '0;
      else if (sel < 85) dose = $urandom_range(32'h0100_0000);
      else dose = $urandom;
      add_point(t, dose);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_time = '0;
    in_dose_amount = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 21;
    recv_idle_pct = 57;
    mismatches = 0;
    quiet_cycles = 0;
    point_taken = 1'b0;
    next_time = '0;
    kel_q = KEL_RESET;
    ka_q = KA_RESET;
    bio_q = F_RESET;
    last_time = '0;
    depot_amt = '0;
    central_amt = '0;
    seen_point = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first point, equal rates, dt zero, backward time, saturation
    add_point(32'h0001_0000, 32'h0064_0000);
    add_point(32'h0001_0000, '0);
    add_point(32'h0002_0000, '0);
    add_point(32'h0002_0001, 32'h0000_0001);
    add_point(32'h0001_8000, '0);
    add_point(32'h0009_0000, 32'hFFFF_FFFF);
    add_point(32'h0009_0000, 32'hFFFF_FFFF);
    add_point(32'h0030_0000, '0);
    add_point(32'hFFFF_FFFF, 32'hAAAA_5555);
    add_point(32'h0000_0000, 32'h5555_AAAA);
    add_point(32'h0000_1000, '0);
    add_random(80);
    drain();

    write_reg(REG_KEL, 24'd0);
    write_reg(REG_KA, 24'hFF_FFFF);
    write_reg(REG_F, 24'hFF_FFFF);
    add_point(next_time + 32'h0001_0000, 32'h0100_0000);
    add_point(next_time + 32'h0000_0001, '0);
    add_point(next_time + 32'h0000_0100, '0);
    add_random(85);
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 21;
    write_reg(REG_KEL, 24'hFF_FFFF);
    write_reg(REG_KA, 24'd0);
    write_reg(REG_F, 24'd0);
    add_point(next_time + 32'h0000_0010, 32'hFFFF_FFFF);
    add_point(next_time + 32'h0100_0000, '0);
    add_random(90);
    drain();

    write_reg(REG_KEL, 24'd104858);
    write_reg(REG_KA, 24'd104860);
    write_reg(REG_F, 24'd16384);
    write_reg(REG_UNUSED, 24'h12_3456);
    add_point(next_time + 32'h0000_0100, 32'h0010_0000);
    add_point(next_time + 32'h0001_0000, '0);
    add_random(70);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_KEL, 24'($urandom_range(24'hFF_FFFF) >> $urandom_range(8)));
      write_reg(REG_KA, 24'($urandom_range(24'hFF_FFFF) >> $urandom_range(8)));
      write_reg(REG_F, 24'($urandom_range(32768)));
      add_random(40);
      drain();
    end

    if (mismatches == 0) begin
      $display("one_compartment_oral_dose_step_core: match");
    end else begin
      $display("one_compartment_oral_dose_step_core: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ocod_pkg.sv
hw/rtl/one_compartment_oral_dose_step_core.sv
hw/rtl/ocod_checker.sv
dv/one_compartment_oral_dose_step_core_tb.sv
